### src/ffp_pkg.sv
// ----------------------------------------------------------------------------
// Feedback frame parser package
// Frame layout constants and the result record shared by the parser modules.
// ----------------------------------------------------------------------------
package ffp_pkg;

	localparam int POS_W = 5;
	localparam int PAYLOAD_WORDS = 7;
	localparam int WIDX_W = 3;

	localparam logic [15:0] START_WORD = 16'hABCD;
	localparam logic [POS_W-1:0] POS_SEARCH = 5'd0;
	localparam logic [POS_W-1:0] POS_FIRST = 5'd2;
	localparam logic [POS_W-1:0] POS_LAST = 5'd17;

	typedef logic [15:0] word_t;

	// One decoded frame: a hit flag and the seven payload words.
	typedef struct packed {
		logic  hit;
		word_t cmd1;
		word_t cmd2;
		word_t speed_r;
		word_t speed_l;
		word_t batt;
		word_t temp;
		word_t led;
	} ffp_frame_t;

endpackage

### src/feedback_frame_parser.sv
// ----------------------------------------------------------------------------
// Feedback frame parser
// Byte stream receiver for 18-byte motor board feedback frames.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, rx_byte) carries one received serial
// byte per transfer. While searching, each byte is paired with the one before it
// as a little-endian word, and 0xABCD opens a frame. The next 16 bytes are
// collected without searching; the last word is a checksum that must equal
// the XOR of the eight words before it. A good frame produces one result on the
// output channel (out_valid, out_ready and the seven field ports); a bad frame
// is dropped silently.
// Bytes are registered in the input stage on acceptance and decoded from
// there; a good frame's result is registered in the result register and
// shows on out_valid until it is taken.
// While in_ready is high the block takes one byte every cycle. A held result
// does not stop the input at once. Only when the final byte of the next frame
// sits in the input stage while the earlier result is still not taken does
// in_ready drop and the next byte wait; results are at least 17 bytes apart.
// Reset clears the search state and both valid flags; the block comes out of
// reset searching, with the previous byte taken as zero.
// ----------------------------------------------------------------------------
module feedback_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] echo_command_one,
	output logic signed [15:0] echo_command_two,
	output logic signed [15:0] speed_right,
	output logic signed [15:0] speed_left,
	output logic signed [15:0] battery_voltage,
	output logic signed [15:0] board_temperature,
	output logic [15:0]        led_command
);
	import ffp_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic       out_valid_q;
	ffp_frame_t frame_q;

	logic       at_last;
	logic       stall;
	logic       proc;
	ffp_frame_t frame;

	// The byte in the input stage may only produce a result when the result
	// register can take it: it is either empty or being emptied now.
	always_comb begin
		stall    = valid_s1 && at_last && out_valid_q && !out_ready;
		proc     = valid_s1 && !stall;
		in_ready = !stall;
	end

	ffp_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (proc),
		.data    (byte_s1),
		.at_last (at_last),
		.frame   (frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && frame.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && frame.hit) begin
			frame_q <= frame;
		end
	end

	assign out_valid         = out_valid_q;
	assign echo_command_one  = signed'(frame_q.cmd1);
	assign echo_command_two  = signed'(frame_q.cmd2);
	assign speed_right       = signed'(frame_q.speed_r);
	assign speed_left        = signed'(frame_q.speed_l);
	assign battery_voltage   = signed'(frame_q.batt);
	assign board_temperature = signed'(frame_q.temp);
	assign led_command       = frame_q.led;

endmodule

### src/ffp_frame_core.sv
// ----------------------------------------------------------------------------
// Feedback frame parser core
// Start word search, byte collection, checksum and the payload word store.
// ----------------------------------------------------------------------------
module ffp_frame_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [7:0]                data,
	output logic                      at_last,
	output ffp_pkg::ffp_frame_t       frame
);
	import ffp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       prev_q;
	logic [7:0]       low_q;
	word_t            xor_q;
	word_t            words_q [PAYLOAD_WORDS];

	logic             in_frame;
	word_t            word;
	logic [3:0]       widx;
	logic             is_payload;
	logic [WIDX_W-1:0] slot;
	word_t            cand;

	always_comb begin
		in_frame   = (pos_q >= POS_FIRST) && (pos_q <= POS_LAST);
		word       = {data, low_q};
		widx       = pos_q[POS_W-1:1];
		is_payload = (widx >= 4'd1) && (widx <= 4'(PAYLOAD_WORDS));
		slot       = widx[WIDX_W-1:0] - WIDX_W'(1);
		cand       = {data, prev_q};
		at_last    = (pos_q == POS_LAST);
	end

	// The checksum word (bus high byte, held low byte) must equal the running XOR.
	always_comb begin
		frame.hit     = in_frame && pos_q[0] && !is_payload && (word == xor_q);
		frame.cmd1    = words_q[0];
		frame.cmd2    = words_q[1];
		frame.speed_r = words_q[2];
		frame.speed_l = words_q[3];
		frame.batt    = words_q[4];
		frame.temp    = words_q[5];
		frame.led     = words_q[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_SEARCH;
			prev_q <= '0;
			xor_q  <= '0;
		end else if (en) begin
			prev_q <= data;
			if (in_frame) begin
				if (pos_q[0] && is_payload) begin
					xor_q <= xor_q ^ word;
				end
				pos_q <= at_last ? POS_SEARCH : pos_q + POS_W'(1);
			end else if (cand == START_WORD) begin
				xor_q <= START_WORD;
				pos_q <= POS_FIRST;
			end else begin
				pos_q <= POS_SEARCH;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_frame) begin
			if (!pos_q[0]) begin
				low_q <= data;
			end else if (is_payload) begin
				words_q[slot] <= word;
			end
		end
	end

endmodule

### src/ffp_checker.sv
// ----------------------------------------------------------------------------
// Feedback frame parser checker
// Port-level properties of the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ffp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] echo_command_one,
	input logic signed [15:0] speed_right,
	input logic [15:0]        led_command
);

	// The input only waits while a result is held by the receiver.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a held result");

	// A result being taken never holds up the input.
	a_ready_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |-> in_ready)
		else $error("input stalled while a result was taken");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn before it was taken");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(echo_command_one) &&
			$stable(speed_right) && $stable(led_command)))
		else $error("result changed while stalled");

endmodule

bind feedback_frame_parser ffp_checker u_ffp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.echo_command_one (echo_command_one),
	.speed_right      (speed_right),
	.led_command      (led_command)
);
